FILE: hdl/csef_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the column surface edge finder.
// Used by csef_scan and the top level; depends on nothing.
package csef_pkg;

  localparam int LOG_W  = 15;
  localparam int GRAD_W = 20;
  localparam int STOP_W = 19;
  localparam int ROW_W  = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 19;
  localparam int SAMPLE_W    = LOG_W + GRAD_W;

  localparam logic [LOG_W-1:0]  EMBED_RESET  = 15'd5018;
  localparam logic [LOG_W-1:0]  SAMPLE_RESET = 15'd5222;
  localparam logic [STOP_W-1:0] STOP_RESET   = 19'd5120;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_EMBED  = 2'd0,
    CFG_SAMPLE = 2'd1,
    CFG_STOP   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [LOG_W-1:0]         log_value;
    logic signed [GRAD_W-1:0] grad_value;
    logic                     last_row;
  } in_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] top_row;
    logic [ROW_W-1:0] bottom_row;
  } out_word_t;

  typedef struct packed {
    logic [LOG_W-1:0]  embed_threshold;
    logic [LOG_W-1:0]  sample_threshold;
    logic [STOP_W-1:0] gradient_stop;
  } cfg_t;

endpackage

FILE: hdl/csef_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; no package needed.
module csef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/csef_scan.sv
`timescale 1ns / 1ps
// Scan sequencer: run search and gradient peak walk over the stored column.
// Depends on csef_pkg; reads the column RAM one row per read state.
module csef_scan import csef_pkg::*; #(
  parameter int MAX_ROWS    = 256,
  parameter int RUN_LENGTH  = 5,
  parameter int PEAK_WINDOW = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  cfg_t                            cfg,
  input  logic                            start,
  input  logic [$clog2(MAX_ROWS+1)-1:0]   rows,
  output logic                            busy,
  output logic                            rd_en,
  output logic [$clog2(MAX_ROWS)-1:0]     rd_addr,
  input  logic [SAMPLE_W-1:0]             rd_data,
  output logic                            done,
  input  logic                            res_ready,
  output out_word_t                       result
);

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int CW  = $clog2(MAX_ROWS + 1);
  localparam int RLW = $clog2(RUN_LENGTH + 1);
  localparam int KW  = $clog2(PEAK_WINDOW);

  typedef enum logic [3:0] {
    S_IDLE, S_TOP_RD, S_TOP_EV, S_TW_RD, S_TW_EV,
    S_BOT_RD, S_BOT_EV, S_BW_RD, S_BW_EV, S_DONE
  } state_t;

  state_t                   state;
  logic [CW-1:0]            h;
  logic [AW-1:0]            idx;
  logic [RLW-1:0]           run_cnt;
  logic [KW-1:0]            kcnt;
  logic signed [GRAD_W-1:0] peak;
  logic [AW-1:0]            best;
  logic [ROW_W-1:0]         top_row;
  logic [ROW_W-1:0]         bottom_row;

  logic [LOG_W-1:0]         d_log;
  logic signed [GRAD_W-1:0] d_grad;
  logic [RLW-1:0]           run_cnt_next;
  logic signed [GRAD_W-1:0] stop_pos;
  logic signed [GRAD_W-1:0] stop_neg;
  logic [CW-1:0]            idx_w;
  logic                     walk_down;
  logic                     at_edge;
  logic                     walk_end;
  logic                     over_sample;
  logic                     improves;
  logic                     past_stop;
  logic                     walk_leave;
  logic                     take_peak;
  logic [AW-1:0]            walk_row;

  function automatic logic [ROW_W-1:0] h9_sat(input logic [8:0] v);
    h9_sat = v[8] ? {ROW_W{1'b1}} : v[ROW_W-1:0];
  endfunction

  assign d_log    = rd_data[SAMPLE_W-1:GRAD_W];
  assign d_grad   = $signed(rd_data[GRAD_W-1:0]);
  assign stop_pos = $signed({1'b0, cfg.gradient_stop});
  assign stop_neg = -stop_pos;
  assign idx_w    = CW'(idx);

  // Run counter: a run opens on a row strictly above the embedding level and
  // grows while rows stay at or above it.
  always_comb begin
    if (d_log < cfg.embed_threshold) begin
      run_cnt_next = '0;
    end else if (run_cnt != '0) begin
      run_cnt_next = run_cnt + RLW'(1);
    end else if (d_log > cfg.embed_threshold) begin
      run_cnt_next = RLW'(1);
    end else begin
      run_cnt_next = '0;
    end
  end

  // Peak walk decisions for the row now on the read data.
  always_comb begin
    walk_down   = (state == S_TW_EV);
    at_edge     = walk_down ? (idx_w == h - CW'(1)) : (idx == '0);
    walk_end    = at_edge || (kcnt == KW'(PEAK_WINDOW - 1));
    over_sample = d_log > cfg.sample_threshold;
    improves    = walk_down ? (d_grad > peak) : (d_grad < peak);
    past_stop   = walk_down ? (peak > stop_pos) : (peak < stop_neg);
    // the run start seeds the peak; a bright row ends the walk on itself
    if (kcnt == '0) begin
      walk_leave = walk_end;
    end else if (over_sample) begin
      walk_leave = 1'b1;
    end else if (improves) begin
      walk_leave = walk_end;
    end else begin
      walk_leave = past_stop || walk_end;
    end
    take_peak = (kcnt == '0) || (!over_sample && improves);
    walk_row  = (kcnt == '0 || over_sample || improves) ? idx : best;
  end

  assign busy    = (state != S_IDLE);
  assign rd_en   = (state == S_TOP_RD) || (state == S_TW_RD) ||
                   (state == S_BOT_RD) || (state == S_BW_RD);
  assign rd_addr = idx;
  assign done    = (state == S_DONE);
  assign result  = '{top_row: top_row, bottom_row: bottom_row};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            h          <= rows;
            top_row    <= '0;
            bottom_row <= h9_sat(9'(rows));
            idx        <= '0;
            run_cnt    <= '0;
            // too few rows for a run: no edge on either side
            state      <= (rows < CW'(RUN_LENGTH + 1)) ? S_DONE : S_TOP_RD;
          end
        end
        S_TOP_RD: state <= S_TOP_EV;
        S_TOP_EV: begin
          if (run_cnt_next == RLW'(RUN_LENGTH)) begin
            run_cnt <= run_cnt_next;
            idx     <= idx - AW'(RUN_LENGTH - 1);
            kcnt    <= '0;
            state   <= S_TW_RD;
          end else if (idx_w == h - CW'(2)) begin
            // no run in the upper part: start the bottom scan at the last row
            run_cnt <= '0;
            idx     <= AW'(h - CW'(1));
            state   <= S_BOT_RD;
          end else begin
            run_cnt <= run_cnt_next;
            idx     <= idx + AW'(1);
            state   <= S_TOP_RD;
          end
        end
        S_TW_RD: state <= S_TW_EV;
        S_TW_EV, S_BW_EV: begin
          if (take_peak) begin
            peak <= d_grad;
            best <= idx;
          end
          if (!walk_leave) begin
            // advance the walk one row away from the run start
            idx   <= walk_down ? idx + AW'(1) : idx - AW'(1);
            kcnt  <= kcnt + KW'(1);
            state <= walk_down ? S_TW_RD : S_BW_RD;
          end else if (walk_down) begin
            // record the top edge and hand over to the bottom scan
            top_row <= ROW_W'(walk_row);
            idx     <= AW'(h - CW'(1));
            run_cnt <= '0;
            state   <= S_BOT_RD;
          end else begin
            bottom_row <= ROW_W'(walk_row);
            state      <= S_DONE;
          end
        end
        S_BOT_RD: state <= S_BOT_EV;
        S_BOT_EV: begin
          run_cnt <= run_cnt_next;
          if (run_cnt_next == RLW'(RUN_LENGTH)) begin
            idx   <= idx + AW'(RUN_LENGTH - 1);
            kcnt  <= '0;
            state <= S_BW_RD;
          end else if (idx == AW'(1)) begin
            state <= S_DONE;
          end else begin
            idx   <= idx - AW'(1);
            state <= S_BOT_RD;
          end
        end
        S_BW_RD: state <= S_BW_EV;
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/column_surface_edge_finder.sv
`timescale 1ns / 1ps
// Column surface edge finder, top level. Accepts one row word per cycle while
// in_ready is high; the word marked last_row starts a scan of R row reads, R at
// most 2*(h-1) + 2*PEAK_WINDOW for h rows. in_ready stays low until the result
// word moves to the output register.
// Synchronous active-high reset restores register defaults and an empty column;
// RAM content is not cleared. Depends on csef_pkg, csef_ram, csef_scan.
module column_surface_edge_finder import csef_pkg::*; #(
  parameter int MAX_ROWS    = 256,
  parameter int RUN_LENGTH  = 5,
  parameter int PEAK_WINDOW = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);

  cfg_t            cfg;
  logic [CW-1:0]   row_count;
  logic [CW-1:0]   rows_stored;
  logic            in_take;
  logic            wr_en;
  logic            scan_busy;
  logic            scan_done;
  logic            res_ready;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [SAMPLE_W-1:0] rd_data;
  out_word_t       scan_result;

  // Configuration registers: always ready, unknown indexes dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{embed_threshold: EMBED_RESET, sample_threshold: SAMPLE_RESET,
               gradient_stop: STOP_RESET};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EMBED:  cfg.embed_threshold  <= cfg_data[LOG_W-1:0];
        CFG_SAMPLE: cfg.sample_threshold <= cfg_data[LOG_W-1:0];
        CFG_STOP:   cfg.gradient_stop    <= cfg_data[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  // Load side: hold off while the scanner owns the RAM.
  assign in_ready    = !scan_busy;
  assign in_take     = in_valid && in_ready;
  assign wr_en       = in_take && (row_count < CW'(MAX_ROWS));
  // Rows in the column including this word; saturates on overflow.
  assign rows_stored = wr_en ? row_count + CW'(1) : row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
    end else if (in_take) begin
      row_count <= in_data.last_row ? '0 : rows_stored;
    end
  end

  csef_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_ROWS)
  ) u_column (
    .clk   (clk),
    .we    (wr_en),
    .waddr (row_count[AW-1:0]),
    .wdata ({in_data.log_value, in_data.grad_value}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  csef_scan #(
    .MAX_ROWS    (MAX_ROWS),
    .RUN_LENGTH  (RUN_LENGTH),
    .PEAK_WINDOW (PEAK_WINDOW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (in_take && in_data.last_row),
    .rows      (rows_stored),
    .busy      (scan_busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .done      (scan_done),
    .res_ready (res_ready),
    .result    (scan_result)
  );

  // Output register: the scanner hands over once the slot is free.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (scan_done && res_ready) begin
      out_valid <= 1'b1;
      out_data  <= scan_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
